### rtl/swfrm_pkg.sv
package swfrm_pkg;

	// field widths
	localparam int TIME_W  = 32;
	localparam int WL_W    = 7;
	localparam int RATE_W  = 24;
	localparam int COUNT_W = 7;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;

	// defaults and constants
	localparam int MAX_WINDOW_DEF = 64;
	localparam logic [WL_W-1:0] WINDOW_RESET = 7'd30;
	localparam int MS_PER_S_Q8 = 256000;
	localparam logic [RATE_W-1:0] RATE_MAX = 24'hFFFFFF;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	// register index, taken from paddr[2]
	localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/swfrm_ram.sv
module swfrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/swfrm_div.sv
module swfrm_div #(
	parameter int NUM_W = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [NUM_W-1:0]               numer,
	input  logic [swfrm_pkg::TIME_W-1:0]   denom,
	output logic [NUM_W-1:0]               quot,
	output swfrm_pkg::div_stat_t           stat
);

	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int TW    = swfrm_pkg::TIME_W;

	// numerator bits shift out at the top while quotient bits shift in below
	logic [NUM_W-1:0] nq_q;
	logic [TW-1:0]    rem_q;
	logic [TW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [TW:0]   trial;
	logic          qbit;
	logic [TW-1:0] rem_next;

	always_comb begin
		trial = {rem_q, nq_q[NUM_W-1]};
		qbit  = (trial >= {1'b0, den_q});
		if (qbit) begin
			rem_next = TW'(trial - {1'b0, den_q});
		end else begin
			rem_next = trial[TW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			nq_q  <= {nq_q[NUM_W-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	assign quot      = nq_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### rtl/sliding_window_frame_rate_meter_unit.sv
// Sliding-window frame rate meter. Each input request carries one frame
// timestamp in milliseconds; the block stores it in a ring of MAX_WINDOW
// entries and returns one result request with the mean frame rate over the
// last window_length frames, (frames - 1) * 256000 / (newest - oldest) in Q8,
// truncated, together with the frame count and a valid flag (cleared for
// fewer than two frames or a zero duration). A frame goes through the ring
// read, then the bit-serial restoring divider over NW, the numerator width
// (24 at MAX_WINDOW = 64), which settles one quotient bit per cycle and is
// skipped when the rate is undefined, then the handoff to the output register.
// A new frame is taken once the result has been loaded into the output
// register, so a result that waits on out_ready does not hold up the next
// frame. window_length sits at byte address 0 of the APB port and resets to
// 30; values above MAX_WINDOW act as MAX_WINDOW. The ring needs no clearing
// after reset.
module sliding_window_frame_rate_meter_unit #(
	parameter int MAX_WINDOW = swfrm_pkg::MAX_WINDOW_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// apb configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [swfrm_pkg::APB_AW-1:0]       paddr,
	input  logic [swfrm_pkg::APB_DW-1:0]       pwdata,
	output logic [swfrm_pkg::APB_DW-1:0]       prdata,
	output logic                               pready,
	// frame request
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [swfrm_pkg::TIME_W-1:0]       frame_time_ms,
	// result request
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [swfrm_pkg::RATE_W-1:0]       rate_q8,
	output logic [swfrm_pkg::COUNT_W-1:0]      frames_in_window,
	output logic                               rate_valid
);

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int LW = (CW > swfrm_pkg::WL_W) ? CW : swfrm_pkg::WL_W;
	localparam int OW = AW + 2;
	localparam int NW = $clog2((MAX_WINDOW - 1) * swfrm_pkg::MS_PER_S_Q8 + 1);
	localparam int QW = (NW > swfrm_pkg::RATE_W) ? NW : swfrm_pkg::RATE_W;
	localparam int TW = swfrm_pkg::TIME_W;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t state_q;

	logic [swfrm_pkg::WL_W-1:0] window_length_q;
	logic [AW-1:0]              write_index_q;
	logic [CW-1:0]              fill_count_q;
	logic [TW-1:0]              time_q;
	logic                       two_q;     // at least two frames held
	logic                       valid_q;   // rate defined for this frame

	logic                          out_valid_q;
	logic [swfrm_pkg::RATE_W-1:0]  rate_q8_q;
	logic [swfrm_pkg::COUNT_W-1:0] frames_q;
	logic                          rate_valid_q;

	// apb: always ready, register index from paddr[2]
	logic cfg_we;
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite
		&& (paddr[2:2] == swfrm_pkg::REG_WINDOW_LENGTH);

	always_comb begin
		if (paddr[2:2] == swfrm_pkg::REG_WINDOW_LENGTH) begin
			prdata = swfrm_pkg::APB_DW'(window_length_q);
		end else begin
			prdata = '0;
		end
	end

	// window bookkeeping for the incoming frame
	logic          accept;
	logic [LW-1:0] wl_ext;
	logic [LW-1:0] lim;
	logic [LW-1:0] inc;
	logic [LW-1:0] cnt_lw;
	logic [CW-1:0] cnt_new;
	logic [AW-1:0] wi_next;
	logic [OW-1:0] diff;
	logic [OW-1:0] oldest_ow;
	logic [AW-1:0] oldest_idx;

	assign accept = in_valid && in_ready;

	always_comb begin
		wl_ext = LW'(window_length_q);
		// effective window saturates at the ring depth
		if (wl_ext > LW'(MAX_WINDOW)) begin
			lim = LW'(MAX_WINDOW);
		end else begin
			lim = wl_ext;
		end
		inc = LW'(fill_count_q) + LW'(1);
		// a shrunk window drops the oldest entries at once
		if (inc > lim) begin
			cnt_lw = lim;
		end else begin
			cnt_lw = inc;
		end
		cnt_new = CW'(cnt_lw);
		if (write_index_q == AW'(MAX_WINDOW - 1)) begin
			wi_next = '0;
		end else begin
			wi_next = write_index_q + 1'b1;
		end
		// oldest slot = (next write slot - count) modulo the ring depth
		diff = OW'(wi_next) + OW'(MAX_WINDOW) - OW'(cnt_new);
		if (diff >= OW'(MAX_WINDOW)) begin
			oldest_ow = diff - OW'(MAX_WINDOW);
		end else begin
			oldest_ow = diff;
		end
		oldest_idx = oldest_ow[AW-1:0];
	end

	// ring store: new timestamp written while the oldest one is read
	logic [TW-1:0] ring_rdata;

	swfrm_ram #(
		.WIDTH(TW),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (accept),
		.waddr(write_index_q),
		.wdata(frame_time_ms),
		.re   (accept),
		.raddr(oldest_idx),
		.rdata(ring_rdata)
	);

	// duration and numerator, formed once the ring read has landed
	logic [TW-1:0] dur;
	logic [CW-1:0] cnt_m1;
	logic [NW-1:0] numer;
	logic          rate_ok;
	logic          div_start;

	assign dur       = time_q - ring_rdata;   // wraps modulo 2^32
	assign cnt_m1    = fill_count_q - 1'b1;
	assign numer     = NW'(NW'(cnt_m1) * NW'(swfrm_pkg::MS_PER_S_Q8));
	assign rate_ok   = two_q && (dur != '0);
	assign div_start = (state_q == ST_READ) && rate_ok;

	logic [NW-1:0]        quot;
	swfrm_pkg::div_stat_t div_stat;

	swfrm_div #(
		.NUM_W(NW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer (numer),
		.denom (dur),
		.quot  (quot),
		.stat  (div_stat)
	);

	// output saturation
	logic [QW-1:0]                 quot_ext;
	logic [swfrm_pkg::RATE_W-1:0]  rate_sat;
	logic [LW-1:0]                 fill_ext;
	logic [swfrm_pkg::COUNT_W-1:0] frames_sat;
	logic                          out_free;
	logic                          load_out;

	always_comb begin
		quot_ext = QW'(quot);
		if (quot_ext > QW'(swfrm_pkg::RATE_MAX)) begin
			rate_sat = swfrm_pkg::RATE_MAX;
		end else begin
			rate_sat = swfrm_pkg::RATE_W'(quot_ext);
		end
		fill_ext = LW'(fill_count_q);
		if (fill_ext > LW'(swfrm_pkg::COUNT_MAX)) begin
			frames_sat = swfrm_pkg::COUNT_MAX;
		end else begin
			frames_sat = swfrm_pkg::COUNT_W'(fill_ext);
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign load_out = (state_q == ST_HOLD) && out_free;
	assign in_ready = (state_q == ST_IDLE);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			window_length_q <= swfrm_pkg::WINDOW_RESET;
			write_index_q   <= '0;
			fill_count_q    <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_length_q <= pwdata[swfrm_pkg::WL_W-1:0];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						write_index_q <= wi_next;
						fill_count_q  <= cnt_new;
						state_q       <= ST_READ;
					end
				end
				ST_READ: begin
					// no divide when the rate is undefined
					if (rate_ok) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_DIV: begin
					if (div_stat.done && !div_stat.busy) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			time_q <= frame_time_ms;
			two_q  <= (cnt_lw >= LW'(2));
		end
		if (state_q == ST_READ) begin
			valid_q <= rate_ok;
		end
		if (load_out) begin
			rate_q8_q    <= valid_q ? rate_sat : '0;
			frames_q     <= frames_sat;
			rate_valid_q <= valid_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign rate_q8          = rate_q8_q;
	assign frames_in_window = frames_q;
	assign rate_valid       = rate_valid_q;

endmodule

### rtl/swfrm_chk.sv
module swfrm_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [swfrm_pkg::RATE_W-1:0]  rate_q8,
	input logic [swfrm_pkg::COUNT_W-1:0] frames_in_window,
	input logic                          rate_valid
);

	// one frame at a time: an accepted request closes the input
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready stayed high after a request");

	// a valid rate needs two frames in the window
	a_valid_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rate_valid |-> frames_in_window >= 7'd2)
		else $error("rate flagged valid with fewer than two frames");

	// an undefined rate reads as zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rate_valid |-> rate_q8 == '0)
		else $error("nonzero rate with valid flag cleared");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rate_q8)
			&& $stable(frames_in_window) && $stable(rate_valid))
		else $error("result changed while stalled");

endmodule

bind sliding_window_frame_rate_meter_unit swfrm_chk u_swfrm_chk (.*);
